[rtl/core/mhic_pkg.sv]
// Shared types and constants for the magnetometer hard-iron calibration block.
// Used by the lane, merge, top-level and checker files. No dependencies.
package mhic_pkg;

  localparam int unsigned MAX_AXES = 3;
  localparam int unsigned AXES_DEF = 3;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;

  localparam int unsigned IN_TDATA_W  = TIME_W + MAX_AXES * SAMPLE_W;
  localparam int unsigned OUT_TDATA_W = MAX_AXES * SAMPLE_W;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 8'd3;

  // Reset values of the configuration registers
  localparam logic signed [SAMPLE_W-1:0] RST_OFFSET_X = 16'sd326;
  localparam logic signed [SAMPLE_W-1:0] RST_OFFSET_Y = 16'sd378;
  localparam logic signed [SAMPLE_W-1:0] RST_OFFSET_Z = -16'sd23;
  localparam logic [TIME_W-1:0]          RST_WINDOW   = 32'd30000000;

  // Item kinds carried in the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // Bit positions in the output tuser
  localparam int unsigned TU_CALIBRATING = 0;
  localparam int unsigned TU_FINISHED    = 1;
  localparam int unsigned TU_HEALTHY     = 2;

  typedef enum logic [1:0] {
    SRC_CFG     = 2'd0,
    SRC_ZERO    = 2'd1,
    SRC_LEARNED = 2'd2
  } offset_src_e;

  // Per-beat control broadcast from the top level to every lane
  typedef struct packed {
    logic        load;   // item accepted this cycle
    logic        start;  // start item: reseed min/max
    logic        track;  // sample inside the window: update min/max
    logic        close;  // sample that closes the window: learn offset
    offset_src_e src;    // offset used for this beat's correction
  } lane_ctrl_t;

  typedef struct packed {
    logic calibrating;
    logic finished;
  } merge_status_t;

endpackage : mhic_pkg

[rtl/core/mhic_lane.sv]
// One axis lane: offset correction, min/max tracking and learned offset.
// Depends on mhic_pkg for the lane control struct and widths.
module mhic_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mhic_pkg::lane_ctrl_t                  ctrl_i,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  cfg_off_i,
  output logic signed [mhic_pkg::SAMPLE_W-1:0]  field_o
);

  logic signed [mhic_pkg::SAMPLE_W-1:0] last_q, last_d;
  logic signed [mhic_pkg::SAMPLE_W-1:0] min_q, min_d;
  logic signed [mhic_pkg::SAMPLE_W-1:0] max_q, max_d;
  logic signed [mhic_pkg::SAMPLE_W-1:0] learned_q, learned_d;

  logic signed [mhic_pkg::SAMPLE_W-1:0] off_w;
  logic signed [mhic_pkg::SAMPLE_W-1:0] corr_w;
  logic signed [mhic_pkg::SAMPLE_W:0]   sum_w;
  logic signed [mhic_pkg::SAMPLE_W:0]   adj_w;

  always_comb begin
    case (ctrl_i.src)
      mhic_pkg::SRC_CFG:  off_w = cfg_off_i;
      mhic_pkg::SRC_ZERO: off_w = '0;
      default:            off_w = learned_q;
    endcase
  end

  // 16-bit wrapping subtract
  assign corr_w = sample_i - off_w;

  // Midpoint truncated toward zero: bias negative sums by one before the halving
  assign sum_w = {min_q[mhic_pkg::SAMPLE_W-1], min_q} + {max_q[mhic_pkg::SAMPLE_W-1], max_q};
  assign adj_w = sum_w + {{mhic_pkg::SAMPLE_W{1'b0}}, sum_w[mhic_pkg::SAMPLE_W]};

  always_comb begin
    last_d    = last_q;
    min_d     = min_q;
    max_d     = max_q;
    learned_d = learned_q;
    if (ctrl_i.load) begin
      if (ctrl_i.start) begin
        min_d = last_q;
        max_d = last_q;
      end else begin
        last_d = corr_w;
        if (ctrl_i.track) begin
          if (corr_w < min_q) min_d = corr_w;
          if (corr_w > max_q) max_d = corr_w;
        end
        if (ctrl_i.close) begin
          learned_d = adj_w[mhic_pkg::SAMPLE_W:1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      min_q     <= '0;
      max_q     <= '0;
      learned_q <= '0;
    end else begin
      last_q    <= last_d;
      min_q     <= min_d;
      max_q     <= max_d;
      learned_q <= learned_d;
    end
  end

  // Start beats report the held reading
  assign field_o = ctrl_i.start ? last_q : corr_w;

endmodule : mhic_lane

[rtl/core/mhic_merge.sv]
// Merge stage: combines lane results, derives health and holds the output beat.
// Depends on mhic_pkg for widths and the status struct.
module mhic_merge #(
  parameter int unsigned AXES = mhic_pkg::AXES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [mhic_pkg::OUT_TDATA_W-1:0]      fields_i,
  input  mhic_pkg::merge_status_t               status_i,
  output logic                                  free_o,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [mhic_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [mhic_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

  logic                                 valid_q, valid_d;
  logic [mhic_pkg::OUT_TDATA_W-1:0]     data_q;
  logic [mhic_pkg::OUT_TUSER_W-1:0]     user_q, user_d;
  logic                                 healthy_w;

  always_comb begin
    healthy_w = 1'b1;
    for (int a = 0; a < mhic_pkg::MAX_AXES; a++) begin
      if (a < AXES && fields_i[a*mhic_pkg::SAMPLE_W +: mhic_pkg::SAMPLE_W] == '0) begin
        healthy_w = 1'b0;
      end
    end
  end

  always_comb begin
    user_d = '0;
    user_d[mhic_pkg::TU_CALIBRATING] = status_i.calibrating;
    user_d[mhic_pkg::TU_FINISHED]    = status_i.finished;
    user_d[mhic_pkg::TU_HEALTHY]     = healthy_w;
  end

  // Register frees up when empty or when its beat leaves this cycle
  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= fields_i;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule : mhic_merge

[rtl/core/mag_hard_iron_calibration.sv]
// Magnetometer hard-iron calibration, min/max method, one lane per axis.
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless stalled; each lane updates its state in the
// accept cycle and the merge register passes the result on while the next beat comes in.
// Reset: asynchronous, active low; clears all calibration state and loads the
// default offsets and window. No clearing pass is needed.
module mag_hard_iron_calibration #(
  parameter int unsigned AXES = mhic_pkg::AXES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: time_us[31:0], sample_x[47:32], sample_y[63:48], sample_z[79:64]
  input  logic [mhic_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: op (0 sample, 1 start calibration)
  input  logic                                 s_axis_tuser,
  // master side
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: field_x[15:0], field_y[31:16], field_z[47:32]
  output logic [mhic_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: calibrating[0], cal_finished[1], healthy[2]
  output logic [mhic_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mhic_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mhic_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic signed [mhic_pkg::SAMPLE_W-1:0] cfg_off_q [mhic_pkg::MAX_AXES];
  logic [mhic_pkg::TIME_W-1:0]          window_q;
  logic [mhic_pkg::TIME_W-1:0]          start_time_q, start_time_d;
  logic                                 cal_active_q, cal_active_d;
  mhic_pkg::offset_src_e                src_q, src_d;

  logic                                 accept_w;
  logic                                 free_w;
  logic [mhic_pkg::TIME_W-1:0]          now_w;
  logic [mhic_pkg::TIME_W-1:0]          elapsed_w;
  logic                                 in_window_w;
  mhic_pkg::lane_ctrl_t                 ctrl_w;
  mhic_pkg::merge_status_t              status_w;
  logic [mhic_pkg::OUT_TDATA_W-1:0]     fields_w;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = free_w;
  assign accept_w      = s_axis_tvalid && free_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_off_q[0] <= mhic_pkg::RST_OFFSET_X;
      cfg_off_q[1] <= mhic_pkg::RST_OFFSET_Y;
      cfg_off_q[2] <= mhic_pkg::RST_OFFSET_Z;
      window_q     <= mhic_pkg::RST_WINDOW;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mhic_pkg::REG_OFFSET_X: cfg_off_q[0] <= cfg_data_i[mhic_pkg::SAMPLE_W-1:0];
        mhic_pkg::REG_OFFSET_Y: cfg_off_q[1] <= cfg_data_i[mhic_pkg::SAMPLE_W-1:0];
        mhic_pkg::REG_OFFSET_Z: cfg_off_q[2] <= cfg_data_i[mhic_pkg::SAMPLE_W-1:0];
        mhic_pkg::REG_WINDOW:   window_q     <= cfg_data_i[mhic_pkg::TIME_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Elapsed time wraps modulo 2^32
  assign now_w       = s_axis_tdata[mhic_pkg::TIME_W-1:0];
  assign elapsed_w   = now_w - start_time_q;
  assign in_window_w = elapsed_w < window_q;

  always_comb begin
    ctrl_w.load  = accept_w;
    ctrl_w.start = (s_axis_tuser == mhic_pkg::OP_START);
    ctrl_w.track = (s_axis_tuser == mhic_pkg::OP_SAMPLE) && cal_active_q && in_window_w;
    ctrl_w.close = (s_axis_tuser == mhic_pkg::OP_SAMPLE) && cal_active_q && !in_window_w;
    ctrl_w.src   = src_q;
  end

  always_comb begin
    start_time_d = start_time_q;
    cal_active_d = cal_active_q;
    src_d        = src_q;
    if (ctrl_w.start) begin
      start_time_d = now_w;
      cal_active_d = 1'b1;
      src_d        = mhic_pkg::SRC_ZERO;
    end else if (ctrl_w.close) begin
      cal_active_d = 1'b0;
      src_d        = mhic_pkg::SRC_LEARNED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      cal_active_q <= 1'b0;
      src_q        <= mhic_pkg::SRC_CFG;
    end else if (accept_w) begin
      start_time_q <= start_time_d;
      cal_active_q <= cal_active_d;
      src_q        <= src_d;
    end
  end

  for (genvar a = 0; a < mhic_pkg::MAX_AXES; a++) begin : g_lane
    if (a < AXES) begin : g_on
      mhic_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl_w),
        .sample_i  (s_axis_tdata[mhic_pkg::TIME_W + a*mhic_pkg::SAMPLE_W +: mhic_pkg::SAMPLE_W]),
        .cfg_off_i (cfg_off_q[a]),
        .field_o   (fields_w[a*mhic_pkg::SAMPLE_W +: mhic_pkg::SAMPLE_W])
      );
    end else begin : g_off
      assign fields_w[a*mhic_pkg::SAMPLE_W +: mhic_pkg::SAMPLE_W] = '0;
    end
  end

  assign status_w.calibrating = cal_active_d;
  assign status_w.finished    = ctrl_w.close;

  mhic_merge #(
    .AXES (AXES)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept_w),
    .fields_i      (fields_w),
    .status_i      (status_w),
    .free_o        (free_w),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule : mag_hard_iron_calibration

[rtl/core/mhic_checker.sv]
// Port-level checks for mag_hard_iron_calibration, attached by bind.
// Depends on mhic_pkg for widths and output tuser bit positions.
module mhic_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [mhic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [mhic_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  // Every accepted beat yields a result beat in the next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // An empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // The closing beat cannot also report an open window
  a_finish_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[mhic_pkg::TU_FINISHED]
      |-> !m_axis_tuser[mhic_pkg::TU_CALIBRATING])
    else $error("finished beat still flagged calibrating");

  // Healthy implies the first axis is nonzero
  a_healthy_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[mhic_pkg::TU_HEALTHY]
      |-> m_axis_tdata[mhic_pkg::SAMPLE_W-1:0] != '0)
    else $error("healthy flagged with zero x field");

  // Hold a stalled result beat
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

endmodule : mhic_checker

bind mag_hard_iron_calibration mhic_checker u_mhic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
